FILE: rtl/dsaf_pkg.sv
// Shared types, constants and helper functions for the domain suffix allow filter.
`timescale 1ns / 1ps
package dsaf_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] name_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic       changed;
    logic [6:0] entries_held;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ENT,
    S_LEN,
    S_RD,
    S_CMP,
    S_DOTRD,
    S_DOTCMP,
    S_CPRD,
    S_CPWR,
    S_MV,
    S_MVLEN,
    S_MVRD,
    S_MVWR,
    S_DONE
  } state_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

FILE: rtl/dsaf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module dsaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/domain_suffix_allow_filter.sv
// Top level of the domain suffix allow filter.
`timescale 1ns / 1ps
// A name streams in one byte per transaction and is stored while it arrives, so
// bytes are taken one per cycle while the filter is idle. After the transaction
// flagged last, a sequencer walks the table entry by entry through the table
// memories, reading and comparing one byte at a time; an add then copies the name
// byte by byte, and a remove moves each later entry down byte by byte. One result
// transaction follows each name; bytes of the next name are taken while that result
// waits, and the next walk may run too, but it holds its own result and takes no
// further bytes until the waiting result is taken.
module domain_suffix_allow_filter #(
  parameter int ENTRIES    = 64,
  parameter int NAME_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dsaf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dsaf_pkg::rsp_t rsp,
  input  logic           blacklist_we,
  input  logic           blacklist_wdata
);

  localparam int NW = $clog2(NAME_BYTES);
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = EW + NW;

  dsaf_pkg::state_t state, state_next;

  logic [1:0]    op_q, op_q_next;
  logic [CW-1:0] i, i_next, count, count_next;
  logic [NW-1:0] j, j_next, dlen, dlen_next, off, off_next;
  logic          res_allowed, res_allowed_next, res_changed, res_changed_next;
  logic          rsp_valid_next;
  dsaf_pkg::rsp_t rsp_next;
  logic          blacklist;

  logic [NW-1:0] nlen, nlen_next, ta, ta_next, tb, tb_next, hlen, hlen_next;
  logic          ended, ended_next, have_nb, have_nb_next, seen_colon, seen_colon_next;

  logic          nm_we;
  logic [NW-1:0] nm_waddr, nm_raddr;
  logic [7:0]    nm_wdata, nm_rdata;
  logic          st_we;
  logic [SW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata, st_rdata;
  logic          ln_we;
  logic [EW-1:0] ln_waddr, ln_raddr;
  logic [NW-1:0] ln_wdata, ln_rdata;

  logic [7:0]    c;
  logic [NW-1:0] tlen;
  logic [CW-1:0] ip1;

  dsaf_ram #(.WIDTH(8), .DEPTH(1 << NW)) u_name (
    .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata),
    .raddr(nm_raddr), .rdata(nm_rdata)
  );

  dsaf_ram #(.WIDTH(8), .DEPTH(1 << SW)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  dsaf_ram #(.WIDTH(NW), .DEPTH(1 << EW)) u_len (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(ln_raddr), .rdata(ln_rdata)
  );

  assign req_ready = (state == dsaf_pkg::S_IDLE);
  assign c         = dsaf_pkg::to_lower(req.name_byte);
  assign tlen      = have_nb ? (tb - ta) : '0;
  assign ip1       = i + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dsaf_pkg::S_IDLE;
      count      <= '0;
      rsp_valid  <= 1'b0;
      blacklist  <= 1'b0;
      nlen       <= '0;
      ended      <= 1'b0;
      have_nb    <= 1'b0;
      seen_colon <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rsp_valid  <= rsp_valid_next;
      nlen       <= nlen_next;
      ended      <= ended_next;
      have_nb    <= have_nb_next;
      seen_colon <= seen_colon_next;
      if (blacklist_we) begin
        blacklist <= blacklist_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q        <= op_q_next;
    i           <= i_next;
    j           <= j_next;
    dlen        <= dlen_next;
    off         <= off_next;
    res_allowed <= res_allowed_next;
    res_changed <= res_changed_next;
    rsp         <= rsp_next;
    ta          <= ta_next;
    tb          <= tb_next;
    hlen        <= hlen_next;
  end

  always_comb begin
    state_next       = state;
    op_q_next        = op_q;
    i_next           = i;
    j_next           = j;
    dlen_next        = dlen;
    off_next         = off;
    count_next       = count;
    res_allowed_next = res_allowed;
    res_changed_next = res_changed;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid;
    nlen_next        = nlen;
    ended_next       = ended;
    have_nb_next     = have_nb;
    seen_colon_next  = seen_colon;
    ta_next          = ta;
    tb_next          = tb;
    hlen_next        = hlen;
    nm_we            = 1'b0;
    nm_waddr         = nlen;
    nm_wdata         = c;
    nm_raddr         = off + j;
    st_we            = 1'b0;
    st_waddr         = {i[EW-1:0], j};
    st_wdata         = nm_rdata;
    st_raddr         = {i[EW-1:0], j};
    ln_we            = 1'b0;
    ln_waddr         = i[EW-1:0];
    ln_wdata         = ln_rdata;
    ln_raddr         = i[EW-1:0];

    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      dsaf_pkg::S_IDLE: begin
        if (req_valid) begin
          if (!ended) begin
            if (c == 8'h00) begin
              ended_next = 1'b1;
            end else if (nlen < NW'(NAME_BYTES - 1)) begin
              nm_we     = 1'b1;
              nlen_next = nlen + NW'(1);
              if (!dsaf_pkg::is_blank(c)) begin
                if (!have_nb) begin
                  ta_next = nlen;
                end
                tb_next      = nlen + NW'(1);
                have_nb_next = 1'b1;
              end
              if (!seen_colon) begin
                if (c == dsaf_pkg::CHAR_COLON) begin
                  seen_colon_next = 1'b1;
                  hlen_next       = nlen;
                end else begin
                  hlen_next = nlen + NW'(1);
                end
              end
            end
          end
          if (req.last) begin
            op_q_next  = req.op;
            state_next = dsaf_pkg::S_START;
          end
        end
      end
      dsaf_pkg::S_START: begin
        i_next           = '0;
        res_allowed_next = 1'b0;
        res_changed_next = 1'b0;
        priority case (op_q)
          dsaf_pkg::OP_LOOKUP: begin
            state_next = (nlen == '0) ? dsaf_pkg::S_DONE : dsaf_pkg::S_ENT;
          end
          dsaf_pkg::OP_ADD: begin
            state_next = (count >= CW'(ENTRIES) || tlen == '0) ?
                         dsaf_pkg::S_DONE : dsaf_pkg::S_ENT;
          end
          dsaf_pkg::OP_REMOVE: begin
            state_next = (tlen == '0) ? dsaf_pkg::S_DONE : dsaf_pkg::S_ENT;
          end
          default: begin
            state_next = dsaf_pkg::S_DONE;
          end
        endcase
      end
      dsaf_pkg::S_ENT: begin
        if (i == count) begin
          if (op_q == dsaf_pkg::OP_LOOKUP) begin
            res_allowed_next = blacklist;
            state_next       = dsaf_pkg::S_DONE;
          end else if (op_q == dsaf_pkg::OP_ADD) begin
            j_next     = '0;
            state_next = dsaf_pkg::S_CPRD;
          end else begin
            state_next = dsaf_pkg::S_DONE;
          end
        end else begin
          state_next = dsaf_pkg::S_LEN;
        end
      end
      dsaf_pkg::S_LEN: begin
        dlen_next = ln_rdata;
        j_next    = '0;
        if (op_q == dsaf_pkg::OP_LOOKUP) begin
          if (ln_rdata == hlen) begin
            off_next   = '0;
            state_next = dsaf_pkg::S_RD;
          end else if ({1'b0, hlen} > {1'b0, ln_rdata} + (NW + 1)'(1)) begin
            off_next   = hlen - ln_rdata;
            state_next = dsaf_pkg::S_DOTRD;
          end else begin
            i_next     = ip1;
            state_next = dsaf_pkg::S_ENT;
          end
        end else if (ln_rdata == tlen) begin
          off_next   = ta;
          state_next = dsaf_pkg::S_RD;
        end else begin
          i_next     = ip1;
          state_next = dsaf_pkg::S_ENT;
        end
      end
      dsaf_pkg::S_RD: begin
        state_next = dsaf_pkg::S_CMP;
      end
      dsaf_pkg::S_CMP: begin
        if (nm_rdata != st_rdata) begin
          i_next     = ip1;
          state_next = dsaf_pkg::S_ENT;
        end else if (j == dlen - NW'(1)) begin
          if (op_q == dsaf_pkg::OP_LOOKUP) begin
            res_allowed_next = !blacklist;
            state_next       = dsaf_pkg::S_DONE;
          end else if (op_q == dsaf_pkg::OP_REMOVE) begin
            state_next = dsaf_pkg::S_MV;
          end else begin
            state_next = dsaf_pkg::S_DONE;
          end
        end else begin
          j_next     = j + NW'(1);
          state_next = dsaf_pkg::S_RD;
        end
      end
      dsaf_pkg::S_DOTRD: begin
        nm_raddr   = off - NW'(1);
        state_next = dsaf_pkg::S_DOTCMP;
      end
      dsaf_pkg::S_DOTCMP: begin
        if (nm_rdata == dsaf_pkg::CHAR_DOT) begin
          state_next = dsaf_pkg::S_RD;
        end else begin
          i_next     = ip1;
          state_next = dsaf_pkg::S_ENT;
        end
      end
      dsaf_pkg::S_CPRD: begin
        nm_raddr   = ta + j;
        state_next = dsaf_pkg::S_CPWR;
      end
      dsaf_pkg::S_CPWR: begin
        st_we    = 1'b1;
        st_waddr = {count[EW-1:0], j};
        if (j == tlen - NW'(1)) begin
          ln_we            = 1'b1;
          ln_waddr         = count[EW-1:0];
          ln_wdata         = tlen;
          count_next       = count + CW'(1);
          res_changed_next = 1'b1;
          state_next       = dsaf_pkg::S_DONE;
        end else begin
          j_next     = j + NW'(1);
          state_next = dsaf_pkg::S_CPRD;
        end
      end
      dsaf_pkg::S_MV: begin
        ln_raddr = ip1[EW-1:0];
        if (ip1 >= count) begin
          count_next       = count - CW'(1);
          res_changed_next = 1'b1;
          state_next       = dsaf_pkg::S_DONE;
        end else begin
          state_next = dsaf_pkg::S_MVLEN;
        end
      end
      dsaf_pkg::S_MVLEN: begin
        ln_we      = 1'b1;
        dlen_next  = ln_rdata;
        j_next     = '0;
        state_next = dsaf_pkg::S_MVRD;
      end
      dsaf_pkg::S_MVRD: begin
        st_raddr   = {ip1[EW-1:0], j};
        state_next = dsaf_pkg::S_MVWR;
      end
      dsaf_pkg::S_MVWR: begin
        st_we    = 1'b1;
        st_wdata = st_rdata;
        if (j == dlen - NW'(1)) begin
          i_next     = ip1;
          state_next = dsaf_pkg::S_MV;
        end else begin
          j_next     = j + NW'(1);
          state_next = dsaf_pkg::S_MVRD;
        end
      end
      dsaf_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.allowed      = res_allowed;
          rsp_next.changed      = res_changed;
          rsp_next.entries_held = 7'(count);
          rsp_valid_next        = 1'b1;
          nlen_next             = '0;
          ended_next            = 1'b0;
          have_nb_next          = 1'b0;
          seen_colon_next       = 1'b0;
          hlen_next             = '0;
          state_next            = dsaf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dsaf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: dv/domain_suffix_allow_filter_tb.sv
// Self-checking testbench for the domain suffix allow filter.
`timescale 1ns / 1ps
module domain_suffix_allow_filter_tb;

  localparam int TABLE_SLOTS = 64;
  localparam int NAME_MAX = 63;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  class verdict_scoreboard;
    logic [7:0] domains[TABLE_SLOTS][NAME_MAX];
    int dom_len[TABLE_SLOTS];
    int held;
    logic [7:0] name_buf[NAME_MAX];
    int name_len;
    bit name_done;
    bit deny_mode;
    dsaf_pkg::rsp_t verdicts[$];
    int mismatches;

    function bit entry_equal(int off, int n, int e);
      if (n != dom_len[e]) return 0;
      for (int k = 0; k < n; k++) if (name_buf[off + k] != domains[e][k]) return 0;
      return 1;
    endfunction

    function int find_entry(int off, int n);
      for (int i = 0; i < held; i++) if (entry_equal(off, n, i)) return i;
      return -1;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function logic lookup_verdict();
      int host_len;
      int dl;
      bit hit;
      host_len = 0;
      hit = 0;
      if (name_len == 0) return 1'b0;
      while (host_len < name_len && name_buf[host_len] != dsaf_pkg::CHAR_COLON)
        host_len++;
      for (int i = 0; i < held && !hit; i++) begin
        dl = dom_len[i];
        if (entry_equal(0, host_len, i)) hit = 1;
        else if (host_len > dl + 1 && name_buf[host_len - dl - 1] == dsaf_pkg::CHAR_DOT &&
                 entry_equal(host_len - dl, dl, i)) hit = 1;
      end
      return deny_mode ? !hit : hit;
    endfunction

    function logic apply_edit(logic [1:0] op);
      int s;
      int e;
      int k;
      s = 0;
      e = name_len;
      while (s < e && is_space(name_buf[s])) s++;
      while (e > s && is_space(name_buf[e - 1])) e--;
      k = find_entry(s, e - s);
      if (op == dsaf_pkg::OP_ADD) begin
        if (held >= TABLE_SLOTS || e == s || k >= 0) return 1'b0;
        for (int j = 0; j < e - s; j++) domains[held][j] = name_buf[s + j];
        dom_len[held] = e - s;
        held++;
        return 1'b1;
      end
      if (k < 0) return 1'b0;
      for (int i = k; i + 1 < held; i++) begin
        domains[i] = domains[i + 1];
        dom_len[i] = dom_len[i + 1];
      end
      held--;
      return 1'b1;
    endfunction

    function void note_input(dsaf_pkg::req_t r);
      dsaf_pkg::rsp_t v;
      logic [7:0] c;
      c = r.name_byte;
      if (!name_done) begin
        if (c == 8'd0) name_done = 1;
        else if (name_len < NAME_MAX) begin
          if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
          name_buf[name_len] = c;
          name_len++;
        end
      end
      if (!r.last) return;
      v = '0;
      if (r.op == dsaf_pkg::OP_LOOKUP) v.allowed = lookup_verdict();
      else if (r.op == dsaf_pkg::OP_ADD || r.op == dsaf_pkg::OP_REMOVE)
        v.changed = apply_edit(r.op);
      v.entries_held = held[6:0];
      verdicts.push_back(v);
      name_len = 0;
      name_done = 0;
    endfunction

    function void check_result(dsaf_pkg::rsp_t r);
      dsaf_pkg::rsp_t v;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", r);
        return;
      end
      v = verdicts.pop_front();
      if (r.allowed !== v.allowed || r.changed !== v.changed ||
          r.entries_held !== v.entries_held) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected allowed=%0d changed=%0d held=%0d, got %0d %0d %0d",
                   v.allowed, v.changed, v.entries_held, r.allowed, r.changed,
                   r.entries_held);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  dsaf_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  dsaf_pkg::rsp_t rsp;
  logic blacklist_we = 1'b0;
  logic blacklist_wdata = 1'b0;

  verdict_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;
  bit hold_off = 0;

  domain_suffix_allow_filter dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .blacklist_we(blacklist_we), .blacklist_wdata(blacklist_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_input(req);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
    end
  end

  initial begin
    int mode;
    int span;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        rsp_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          2: rsp_ready <= ($urandom_range(0, 7) == 0);
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #100000000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(logic [1:0] op, logic [7:0] b, logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= '{op: op, name_byte: b, last: lst};
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  task automatic send_name(logic [1:0] op, byte_q_t q);
    logic [1:0] o;
    if (q.size() == 0) q.push_back(8'd0);
    foreach (q[i]) begin
      o = op;
      if (i != q.size() - 1 && $urandom_range(0, 9) == 0) o = 2'($urandom_range(0, 3));
      send_item(o, q[i], i == q.size() - 1);
    end
  endtask

  function automatic byte_q_t from_str(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic byte_q_t random_name(logic [1:0] op);
    string bases[8] = '{"ab", "ab.cd", "cd", "x.ab", "e.f.g", "q", "zab", "f.g"};
    logic [7:0] blanks[4] = '{8'd32, 8'd9, 8'd13, 8'd10};
    byte_q_t q;
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 80) : $urandom_range(1, 8);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    if ($urandom_range(0, 3) == 0) q = from_str($urandom_range(0, 1) ? "w." : "zz");
    q = {q, from_str(bases[$urandom_range(0, 7)])};
    foreach (q[i])
      if (q[i] >= 8'h61 && q[i] <= 8'h7a && $urandom_range(0, 4) == 0) q[i] = q[i] - 8'h20;
    if (op == dsaf_pkg::OP_LOOKUP && $urandom_range(0, 4) == 0) q = {q, from_str(":80")};
    if (op == dsaf_pkg::OP_LOOKUP && $urandom_range(0, 19) == 0)
      q.push_front(dsaf_pkg::CHAR_COLON);
    if (op != dsaf_pkg::OP_LOOKUP && $urandom_range(0, 2) == 0) begin
      q.push_front(blanks[$urandom_range(0, 3)]);
      q.push_back(blanks[$urandom_range(0, 3)]);
    end
    if ($urandom_range(0, 9) == 0) begin
      q.push_back(8'd0);
      q.push_back(8'($urandom_range(1, 255)));
    end
    return q;
  endfunction

  task automatic pause_sender();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic settle_and_configure(logic deny);
    pause_sender();
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    blacklist_we <= 1'b1;
    blacklist_wdata <= deny;
    @(posedge clk);
    blacklist_we <= 1'b0;
    sb.deny_mode = deny;
    @(posedge clk);
  endtask

  function automatic logic [1:0] random_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return dsaf_pkg::OP_LOOKUP;
    if (r < 14) return dsaf_pkg::OP_ADD;
    if (r < 19) return dsaf_pkg::OP_REMOVE;
    return OP_NONE;
  endfunction

  initial begin
    byte_q_t q;
    logic [1:0] op;
    int order[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_name(dsaf_pkg::OP_LOOKUP, q);
    send_name(dsaf_pkg::OP_ADD, from_str("AB"));
    send_name(dsaf_pkg::OP_LOOKUP, from_str("x.ab:9"));
    send_name(dsaf_pkg::OP_LOOKUP, from_str(":"));
    send_name(OP_NONE, from_str("ab"));
    send_name(dsaf_pkg::OP_ADD, from_str(" ab\t"));
    send_name(dsaf_pkg::OP_REMOVE, from_str("ab"));
    send_name(dsaf_pkg::OP_REMOVE, from_str("ab"));
    send_name(dsaf_pkg::OP_ADD, from_str(" "));
    q = from_str("ab");
    q = {q, 8'd0, 8'd122};
    send_name(dsaf_pkg::OP_LOOKUP, q);
    q = {8'd255};
    send_name(dsaf_pkg::OP_LOOKUP, q);

    settle_and_configure(1'b1);
    send_name(dsaf_pkg::OP_LOOKUP, from_str(":x"));
    send_name(dsaf_pkg::OP_LOOKUP, from_str("zab"));

    // Fill the table past capacity, probe it, then remove half of its entries in random order.
    for (int n = 0; n < 68; n++) begin
      q = {8'h74, 8'h61 + n[7:4], 8'h61 + n[3:0]};
      send_name(dsaf_pkg::OP_ADD, q);
      if (n == 40) hold_off = 1;
    end
    for (int n = 0; n < 10; n++) begin
      q = from_str("s.t");
      q = {q, 8'h61 + n[3:0]};
      send_name(dsaf_pkg::OP_LOOKUP, q);
    end
    settle_and_configure(1'b0);
    for (int n = 0; n < 64; n++) order.push_back(n);
    order.shuffle();
    foreach (order[i]) begin
      q = {8'h74, 8'h61 + order[i][7:4], 8'h61 + order[i][3:0]};
      if (i % 2 == 0) send_name(dsaf_pkg::OP_REMOVE, q);
    end

    while (items_sent < 600) begin
      if (items_sent % 150 < 8) settle_and_configure(1'($urandom_range(0, 1)));
      op = random_op();
      send_name(op, random_name(op));
    end
    settle_and_configure(1'b0);
    for (int n = 0; n < 6; n++)
      send_name(dsaf_pkg::OP_LOOKUP, random_name(dsaf_pkg::OP_LOOKUP));

    pause_sender();
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dsaf_pkg.sv
rtl/dsaf_ram.sv
rtl/domain_suffix_allow_filter.sv
dv/domain_suffix_allow_filter_tb.sv
